// ----- sv/pfat_pkg.sv -----
// Shared types and constants of the page frame allocator and translator.
package pfat_pkg;

   localparam int NUM_FRAMES    = 256;
   localparam int MAX_JOBS      = 16;
   localparam int MAX_JOB_BYTES = 104857600;
   localparam int FRAME_AW      = $clog2(NUM_FRAMES);
   localparam int FRAME_CW      = FRAME_AW + 1;
   localparam int SLOT_AW       = $clog2(MAX_JOBS);
   localparam int PS_W          = 21;
   localparam int PS_CAP        = 1048576;
   localparam int PS_RESET      = 4096;
   localparam int SIZE_W        = 27;
   localparam int ID_W          = 16;
   localparam int LIM_W         = 9;
   localparam int CNT_W         = 9;
   localparam int IDENT_LAST    = 65535;
   localparam int CSR_W         = 21;
   localparam int DIV_STEPS     = SIZE_W;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
   localparam int PAGE_W        = 8;
   localparam int OFF_W         = 20;
   localparam int PHYS_W        = 28;
   localparam int PROD_W        = FRAME_AW + PS_W;
   localparam int RAM_W         = SLOT_AW + PAGE_W;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_TRANSLATE,
      OP_REMOVE,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_BAD_SIZE,
      ST_NO_FRAMES,
      ST_TABLE_FULL,
      ST_NOT_FOUND,
      ST_OUT_OF_BOUNDS,
      ST_ID_ZERO
   } status_type;

   typedef enum logic {
      CSR_PAGE_SIZE,
      CSR_FRAMES_IN_USE
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_TR_CHECK,
      S_COUNT,
      S_PLACE,
      S_SCAN_TR,
      S_PHYS,
      S_SCAN_RM
   } state_type;

   typedef struct packed {
      op_type                   op;
      logic [SIZE_W-1:0]        job_size;
      logic [ID_W-1:0]          job_id;
      logic [SIZE_W-1:0]        logical_address;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [ID_W-1:0]          assigned_id;
      logic [CNT_W-1:0]         page_count;
      logic [OFF_W-1:0]         fragmentation;
      logic [PAGE_W-1:0]        page_index;
      logic [OFF_W-1:0]         page_offset;
      logic [PAGE_W-1:0]        frame_number;
      logic [PHYS_W-1:0]        physical_address;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       div_init;
      logic       div_step;
      logic       scan_clr;
      logic       count_step;
      logic       place_step;
      logic       read_step;
      logic       mul;
      logic       commit_alloc;
      logic       commit_remove;
      logic       respond;
      status_type status;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   size_bad;
      logic   id_zero;
      logic   found;
      logic   addr_oob;
      logic   pg_oob;
      logic   div_last;
      logic   count_end;
      logic   place_end;
      logic   scan_end;
      logic   frames_short;
      logic   slot_free;
      logic   ident_ok;
      logic   hit;
   } sts_type;

endpackage

// ----- sv/pfat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// ----- sv/pfat_ctrl.sv -----
// Controller state machine that sequences each request through the datapath.
module pfat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output pfat_pkg::cmd_type cmd,
   input  pfat_pkg::sts_type sts
);
   import pfat_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.scan_clr = 1'b1;
            case (sts.op)
               OP_ALLOC: begin
                  if (sts.size_bad) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_BAD_SIZE;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.div_init = 1'b1;
                     state_in     = S_DIV;
                  end
               end
               OP_TRANSLATE: begin
                  if (!sts.found) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_NOT_FOUND;
                     state_in    = S_IDLE;
                  end else if (sts.addr_oob) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_OUT_OF_BOUNDS;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.div_init = 1'b1;
                     state_in     = S_DIV;
                  end
               end
               OP_REMOVE: begin
                  if (sts.id_zero) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_ID_ZERO;
                     state_in    = S_IDLE;
                  end else if (!sts.found) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_NOT_FOUND;
                     state_in    = S_IDLE;
                  end else begin
                     state_in = S_SCAN_RM;
                  end
               end
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = (sts.op == OP_ALLOC) ? S_COUNT : S_TR_CHECK;
            end
         end
         S_TR_CHECK: begin
            if (sts.pg_oob) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_OUT_OF_BOUNDS;
               state_in    = S_IDLE;
            end else begin
               state_in = S_SCAN_TR;
            end
         end
         S_COUNT: begin
            cmd.count_step = 1'b1;
            if (sts.count_end) begin
               if (sts.frames_short) begin
                  cmd.respond = 1'b1;
                  cmd.status  = ST_NO_FRAMES;
                  state_in    = S_IDLE;
               end else if (!sts.slot_free || !sts.ident_ok) begin
                  cmd.respond = 1'b1;
                  cmd.status  = ST_TABLE_FULL;
                  state_in    = S_IDLE;
               end else begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_PLACE;
               end
            end
         end
         S_PLACE: begin
            if (sts.place_end) begin
               cmd.commit_alloc = 1'b1;
               cmd.respond      = 1'b1;
               state_in         = S_IDLE;
            end else begin
               cmd.place_step = 1'b1;
            end
         end
         S_SCAN_TR: begin
            cmd.read_step = 1'b1;
            if (sts.scan_end) begin
               if (sts.hit) begin
                  cmd.mul  = 1'b1;
                  state_in = S_PHYS;
               end else begin
                  cmd.respond = 1'b1;
                  cmd.status  = ST_OUT_OF_BOUNDS;
                  state_in    = S_IDLE;
               end
            end
         end
         S_PHYS: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         S_SCAN_RM: begin
            cmd.read_step = 1'b1;
            if (sts.scan_end) begin
               cmd.commit_remove = 1'b1;
               cmd.respond       = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// ----- sv/pfat_dp.sv -----
// Datapath: settings, frame and job tables, divider, frame scan and result register.
module pfat_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  pfat_pkg::req_type             req_data,
   input  logic                          csr_we,
   input  pfat_pkg::csr_index_type       csr_index,
   input  logic [pfat_pkg::CSR_W-1:0]    csr_wdata,
   input  pfat_pkg::cmd_type             cmd,
   output pfat_pkg::sts_type             sts,
   output logic                          rsp_strobe,
   output pfat_pkg::rsp_type             rsp_data
);
   import pfat_pkg::*;

   logic [PS_W-1:0]       page_size_ff;
   logic [LIM_W-1:0]      frames_ff;
   req_type               req_ff;
   logic [NUM_FRAMES-1:0] busy_ff, busy_in;
   logic [MAX_JOBS-1:0]   valid_ff;
   logic [ID_W-1:0]       ident_ff [MAX_JOBS];
   logic [SIZE_W-1:0]     bytes_ff [MAX_JOBS];
   logic [CNT_W-1:0]      pages_ff [MAX_JOBS];
   logic [ID_W-1:0]       next_ident_ff;
   logic [SIZE_W-1:0]     dd_ff, quo_ff;
   logic [PS_W-1:0]       rem_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [FRAME_CW-1:0]   idx_ff;
   logic [FRAME_AW-1:0]   idx_d_ff;
   logic                  vld_d_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  hit_ff;
   logic [FRAME_AW-1:0]   frame_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  strobe_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [PS_W-1:0]       ps_eff;
   logic [LIM_W-1:0]      lim_eff;
   logic [PS_W:0]         div_t;
   logic                  div_ge;
   logic [SIZE_W-1:0]     need;
   logic [MAX_JOBS-1:0]   slot_hit;
   logic [SLOT_AW-1:0]    hit_idx, free_idx, slot_sel;
   logic                  free_any;
   logic                  frame_idle;
   logic                  ram_we;
   logic [RAM_W-1:0]      ram_rdata;
   logic                  match;
   logic [OFF_W:0]        frag;

   always_comb begin
      if (page_size_ff == '0) begin
         ps_eff = PS_W'(1);
      end else if (page_size_ff > PS_W'(PS_CAP)) begin
         ps_eff = PS_W'(PS_CAP);
      end else begin
         ps_eff = page_size_ff;
      end
      lim_eff = (frames_ff > LIM_W'(NUM_FRAMES)) ? LIM_W'(NUM_FRAMES) : frames_ff;
   end

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      free_any = 1'b0;
      for (int s = MAX_JOBS - 1; s >= 0; s--) begin
         slot_hit[s] = valid_ff[s] && (ident_ff[s] == req_ff.job_id);
         if (slot_hit[s]) begin
            hit_idx = SLOT_AW'(s);
         end
         if (!valid_ff[s]) begin
            free_idx = SLOT_AW'(s);
            free_any = 1'b1;
         end
      end
      slot_sel = (req_ff.op == OP_ALLOC) ? free_idx : hit_idx;
   end

   assign div_t  = {rem_ff, dd_ff[SIZE_W-1]};
   assign div_ge = (div_t >= {1'b0, ps_eff});
   assign need   = quo_ff + SIZE_W'(rem_ff != '0);
   assign frame_idle = !busy_ff[idx_ff[FRAME_AW-1:0]];
   assign ram_we = cmd.place_step && (idx_ff < FRAME_CW'(lim_eff)) && frame_idle
                   && (SIZE_W'(cnt_ff) < need);
   assign match  = vld_d_ff && busy_ff[idx_d_ff] && (ram_rdata[RAM_W-1:PAGE_W] == slot_sel)
                   && ((req_ff.op == OP_REMOVE)
                       || (ram_rdata[PAGE_W-1:0] == quo_ff[PAGE_W-1:0]));

   pfat_ram #(.WIDTH(RAM_W), .DEPTH(NUM_FRAMES)) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx_ff[FRAME_AW-1:0]),
      .wdata ({slot_sel, cnt_ff[PAGE_W-1:0]}),
      .raddr (idx_ff[FRAME_AW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (cmd.scan_clr) begin
         cnt_in = '0;
      end else if (cmd.count_step) begin
         if ((idx_ff < FRAME_CW'(lim_eff)) && frame_idle) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end else if (ram_we) begin
         busy_in[idx_ff[FRAME_AW-1:0]] = 1'b1;
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.read_step && match && (req_ff.op == OP_REMOVE)) begin
         busy_in[idx_d_ff] = 1'b0;
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      frag   = (rem_ff != '0) ? (OFF_W + 1)'(ps_eff - rem_ff) : '0;
      rsp_in = '0;
      rsp_in.status = cmd.status;
      if (cmd.status == ST_OK) begin
         case (req_ff.op)
            OP_ALLOC: begin
               rsp_in.assigned_id   = next_ident_ff;
               rsp_in.page_count    = need[CNT_W-1:0];
               rsp_in.fragmentation = frag[OFF_W-1:0];
            end
            OP_TRANSLATE: begin
               rsp_in.page_index       = quo_ff[PAGE_W-1:0];
               rsp_in.page_offset      = rem_ff[OFF_W-1:0];
               rsp_in.frame_number     = frame_ff;
               rsp_in.physical_address = PHYS_W'(prod_ff + PROD_W'(rem_ff));
            end
            OP_REMOVE: begin
               rsp_in.page_count = cnt_ff;
            end
            default: begin
               rsp_in.status = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff  <= PS_W'(PS_RESET);
         frames_ff     <= LIM_W'(NUM_FRAMES);
         busy_ff       <= '0;
         valid_ff      <= '0;
         next_ident_ff <= ID_W'(1);
         strobe_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PAGE_SIZE:     page_size_ff <= csr_wdata[PS_W-1:0];
               CSR_FRAMES_IN_USE: frames_ff    <= csr_wdata[LIM_W-1:0];
               default:           frames_ff    <= frames_ff;
            endcase
         end
         busy_ff   <= busy_in;
         strobe_ff <= cmd.respond;
         if (cmd.commit_alloc) begin
            valid_ff[free_idx] <= 1'b1;
            next_ident_ff      <= next_ident_ff + ID_W'(1);
         end
         if (cmd.commit_remove) begin
            valid_ff[hit_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.commit_alloc) begin
         ident_ff[free_idx] <= next_ident_ff;
         bytes_ff[free_idx] <= req_ff.job_size;
         pages_ff[free_idx] <= need[CNT_W-1:0];
      end
      if (cmd.div_init) begin
         dd_ff      <= (req_ff.op == OP_ALLOC) ? req_ff.job_size : req_ff.logical_address;
         quo_ff     <= '0;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dd_ff      <= {dd_ff[SIZE_W-2:0], 1'b0};
         quo_ff     <= {quo_ff[SIZE_W-2:0], div_ge};
         rem_ff     <= div_ge ? div_t[PS_W-1:0] - ps_eff : div_t[PS_W-1:0];
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
      cnt_ff <= cnt_in;
      if (cmd.scan_clr) begin
         idx_ff   <= '0;
         vld_d_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else if (cmd.count_step || ram_we || (cmd.place_step && !ram_we)) begin
         idx_ff <= idx_ff + FRAME_CW'(1);
      end else if (cmd.read_step) begin
         if (idx_ff < FRAME_CW'(NUM_FRAMES)) begin
            idx_ff <= idx_ff + FRAME_CW'(1);
         end
         vld_d_ff <= (idx_ff < FRAME_CW'(NUM_FRAMES));
         idx_d_ff <= idx_ff[FRAME_AW-1:0];
         if (match && (req_ff.op == OP_TRANSLATE)) begin
            hit_ff   <= 1'b1;
            frame_ff <= idx_d_ff;
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(frame_ff) * PROD_W'(ps_eff);
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      sts.op           = req_ff.op;
      sts.size_bad     = (req_ff.job_size == '0)
                         || (req_ff.job_size > SIZE_W'(MAX_JOB_BYTES));
      sts.id_zero      = (req_ff.job_id == '0);
      sts.found        = |slot_hit;
      sts.addr_oob     = (req_ff.logical_address >= bytes_ff[hit_idx]);
      sts.pg_oob       = (quo_ff >= SIZE_W'(pages_ff[hit_idx]));
      sts.div_last     = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
      sts.count_end    = (idx_ff >= FRAME_CW'(lim_eff));
      sts.place_end    = (idx_ff >= FRAME_CW'(lim_eff)) || (SIZE_W'(cnt_ff) >= need);
      sts.scan_end     = (idx_ff == FRAME_CW'(NUM_FRAMES)) && !vld_d_ff;
      sts.frames_short = (SIZE_W'(cnt_ff) < need);
      sts.slot_free    = free_any;
      sts.ident_ok     = (next_ident_ff != ID_W'(IDENT_LAST)) && (next_ident_ff != '0);
      sts.hit          = hit_ff;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
endmodule

// ----- sv/page_frame_allocator_translator.sv -----
// Top level of the page frame allocator and address translator.
//
//   Port group   Direction   Handshake
//   req_         in          start and not busy accepts one request
//   rsp_         out         rsp_strobe marks a result for one cycle
//   csr_         in          csr_we writes csr_index at once
//
// Allocate runs the bit-serial divider, a counting pass over the frame table and a placing
// pass that stops once the job is placed. Translate and remove scan all 256 frame table
// entries through the frame RAM read port. A request rejected at decode gives its result
// through the decode state and then the registered result strobe. Reset clears all jobs
// and frames at once. Results cannot be stalled.
module page_frame_allocator_translator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  pfat_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output pfat_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  pfat_pkg::csr_index_type       csr_index,
   input  logic [pfat_pkg::CSR_W-1:0]    csr_wdata
);
   import pfat_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pfat_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   pfat_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );
endmodule

// ----- sv/pfat_chk.sv -----
// Port-level checker for the page frame allocator, with its bind statement.
module pfat_chk (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input pfat_pkg::rsp_type rsp_data
);
   import pfat_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("Block is not idle after reset.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted request did not make the block busy.");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("Result appeared without a request in progress.");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("More than one result for one request.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status != ST_OK) |->
         (rsp_data.assigned_id == '0) && (rsp_data.page_count == '0)
         && (rsp_data.physical_address == '0))
      else $error("Failed request returned nonzero fields.");
endmodule

bind page_frame_allocator_translator pfat_chk u_pfat_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
